>>> hdl/sm3_pkg.sv
// ============================================================================
// SM3 package
// Shared types, constants and round functions for the SM3 hash engine.
// ============================================================================
`default_nettype none
package sm3_pkg;

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;

    localparam word_t IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

    // One queued word from the front part to the back part.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
    } qitem_t;

    function automatic word_t rol(input word_t x, input logic [4:0] n);
        logic [63:0] d;
        begin
            d = {x, x} << n;
            return d[63:32];
        end
    endfunction

    function automatic word_t p0(input word_t x);
        return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
    endfunction

    function automatic word_t p1(input word_t x);
        return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
    endfunction

endpackage
`default_nettype wire

>>> hdl/sm3_front.sv
// ============================================================================
// SM3 front part
// Accepts input words, clamps the byte count and queues them for the core.
// ============================================================================
`default_nettype none
module sm3_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [31:0]     in_data,
    input  wire logic [2:0]      in_nbytes,
    input  wire logic            in_last,
    output logic                 q_valid,
    input  wire logic            q_ready,
    output sm3_pkg::qitem_t      q_item
);

    sm3_pkg::qitem_t buf_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic            push, pop;
    sm3_pkg::qitem_t item;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        item.data   = in_data;
        item.nbytes = (in_nbytes > 3'd4) ? 3'd4 : in_nbytes;
        item.last   = in_last;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

>>> hdl/sm3_core.sv
// ============================================================================
// SM3 back part
// Fills blocks byte-wise, pads, compresses one round per cycle and emits the
// digest.
// ============================================================================
`default_nettype none
module sm3_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire sm3_pkg::qitem_t q_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [31:0]          out_digest,
    output logic [2:0]           out_index,
    output logic                 out_last
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_BYTE  = 7'b0000010,
        S_PAD   = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_ROUND = 7'b0010000,
        S_FOLD  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t         state_reg;
    logic [31:0]    blk_reg [16];
    logic [31:0]    w_reg [16];
    logic [31:0]    r_reg [8];
    logic [31:0]    cv_reg [8];
    logic [5:0]     fill_reg;
    logic [60:0]    cnt_reg;
    logic [31:0]    data_reg;
    logic [2:0]     left_reg;
    logic           last_reg;
    logic           final_reg;
    logic           padded_reg;
    logic [5:0]     rnd_reg;
    logic [2:0]     oidx_reg;

    logic [31:0]    tj, a12, ss1, ss2, ff, gg, tt1, tt2, nw;
    logic [3:0]     bidx;
    logic [4:0]     bsh;
    logic [7:0]     byte_v;
    logic [31:0]    bmask;
    logic [60:0]    len;

    assign q_ready    = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign out_digest = cv_reg[oidx_reg];
    assign out_index  = oidx_reg;
    assign out_last   = (oidx_reg == 3'd7);
    assign len        = cnt_reg;

    always_comb
    begin
        tj  = rnd_reg[5:4] == 2'd0 ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
        a12 = sm3_pkg::rol(r_reg[0], 5'd12);
        ss1 = sm3_pkg::rol(a12 + r_reg[4] + sm3_pkg::rol(tj, rnd_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (rnd_reg[5:4] == 2'd0)
        begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end
        else
        begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + r_reg[7] + ss1 + w_reg[0];
        nw  = sm3_pkg::p1(w_reg[0] ^ w_reg[7] ^ sm3_pkg::rol(w_reg[13], 5'd15))
              ^ sm3_pkg::rol(w_reg[3], 5'd7) ^ w_reg[10];
        bidx = fill_reg[5:2];
        bsh  = 5'd24 - {fill_reg[1:0], 3'b000};
        bmask = ~(32'h000000FF << bsh);
        if (state_reg == S_BYTE)
            byte_v = data_reg[31:24];
        else if (!padded_reg)
            byte_v = sm3_pkg::PAD_BYTE;
        else
            byte_v = 8'h00;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_BYTE && left_reg != 3'd0) || state_reg == S_PAD)
        begin
            if (state_reg == S_PAD && padded_reg && fill_reg >= 6'd56 && final_reg)
            begin
                blk_reg[14] <= {len[60:29]};
                blk_reg[15] <= {len[28:0], 3'b000};
            end
            else
                blk_reg[bidx] <= (blk_reg[bidx] & bmask) | ({24'h0, byte_v} << bsh);
        end
        if (state_reg == S_ROUND)
        begin
            for (int k = 0; k < 15; k++)
                w_reg[k] <= w_reg[k + 1];
            w_reg[15] <= nw;
            r_reg[3] <= r_reg[2];
            r_reg[2] <= sm3_pkg::rol(r_reg[1], 5'd9);
            r_reg[1] <= r_reg[0];
            r_reg[0] <= tt1;
            r_reg[7] <= r_reg[6];
            r_reg[6] <= sm3_pkg::rol(r_reg[5], 5'd19);
            r_reg[5] <= r_reg[4];
            r_reg[4] <= sm3_pkg::p0(tt2);
        end
        else
        begin
            for (int k = 0; k < 16; k++)
                w_reg[k] <= blk_reg[k];
            for (int k = 0; k < 8; k++)
                r_reg[k] <= cv_reg[k];
        end
        if (state_reg == S_IDLE && q_valid)
            data_reg <= q_item.data;
        else if (state_reg == S_BYTE && left_reg != 3'd0)
            data_reg <= {data_reg[23:0], 8'h00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= 6'd0;
            cnt_reg    <= 61'd0;
            left_reg   <= 3'd0;
            last_reg   <= 1'b0;
            final_reg  <= 1'b0;
            padded_reg <= 1'b0;
            rnd_reg    <= 6'd0;
            oidx_reg   <= 3'd0;
            for (int k = 0; k < 8; k++)
                cv_reg[k] <= sm3_pkg::IV[k];
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        left_reg  <= q_item.nbytes;
                        last_reg  <= q_item.last;
                        cnt_reg   <= cnt_reg + {58'd0, q_item.nbytes};
                        state_reg <= S_BYTE;
                    end
                end
                S_BYTE:
                begin
                    if (left_reg != 3'd0)
                    begin
                        left_reg <= left_reg - 3'd1;
                        fill_reg <= fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            final_reg <= 1'b0;
                            rnd_reg   <= 6'd0;
                            state_reg <= S_LOAD;
                        end
                    end
                    else if (last_reg)
                    begin
                        padded_reg <= 1'b0;
                        state_reg  <= S_PAD;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_PAD:
                begin
                    padded_reg <= 1'b1;
                    if (padded_reg && fill_reg >= 6'd56 && final_reg)
                    begin
                        rnd_reg   <= 6'd0;
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        fill_reg <= fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            rnd_reg   <= 6'd0;
                            state_reg <= S_LOAD;
                        end
                        if (!padded_reg && fill_reg < 6'd56)
                            final_reg <= 1'b1;
                        else if (fill_reg == 6'd55 || (padded_reg && fill_reg == 6'd63))
                            final_reg <= 1'b1;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                        state_reg <= S_FOLD;
                end
                S_FOLD:
                begin
                    for (int k = 0; k < 8; k++)
                        cv_reg[k] <= cv_reg[k] ^ r_reg[k];
                    if (last_reg && padded_reg && final_reg && fill_reg >= 6'd56)
                    begin
                        oidx_reg  <= 3'd0;
                        state_reg <= S_OUT;
                    end
                    else if (last_reg && padded_reg)
                    begin
                        fill_reg  <= 6'd0;
                        state_reg <= S_PAD;
                    end
                    else
                        state_reg <= S_BYTE;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int k = 0; k < 8; k++)
                                cv_reg[k] <= sm3_pkg::IV[k];
                            fill_reg   <= 6'd0;
                            cnt_reg    <= 61'd0;
                            last_reg   <= 1'b0;
                            final_reg  <= 1'b0;
                            padded_reg <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hdl/sm3_hash_engine_unit.sv
// SM3 hash engine. Each message word leaves the input queue, its valid bytes
// are written one by one into the block filler and one more step closes the
// word; the core takes the next word from the two-entry queue only when it is
// back in idle. Each full 64-byte block then loads the schedule, runs 64
// rounds in the single round unit and folds into the chaining value. A final
// word adds padding, one or two compressions, and eight digest words that
// leave one per accepted cycle.
// ============================================================================
// SM3 hash engine top level
// Input queue in front of a one-round-per-cycle SM3 compression core.
// ============================================================================
`default_nettype none
module sm3_hash_engine_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // data_word[31:0], valid_bytes[34:32], zero fill
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic             m_tlast
);

    logic            q_valid, q_ready;
    sm3_pkg::qitem_t q_item;
    logic [31:0]     dig;
    logic [2:0]      idx;

    sm3_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data(s_tdata[31:0]), .in_nbytes(s_tdata[34:32]), .in_last(s_tlast),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    sm3_core u_core (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_digest(dig), .out_index(idx), .out_last(m_tlast)
    );

    assign m_tdata = {5'd0, idx, dig};

endmodule
`default_nettype wire

>>> hdl/sm3_checker.sv
// ============================================================================
// SM3 port checker
// Watches the output-side top-level ports of the SM3 hash engine.
// ============================================================================
`default_nettype none
module sm3_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)))
        else $error("tlast does not match word index");

    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)
        else $error("digest words not consecutive");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:35] == 5'd0)
        else $error("fill bits not zero");

endmodule

bind sm3_hash_engine_unit sm3_checker u_chk (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
